>>> rtl/accumulator_alu_skip_unit_assert.svh
// Assertion macros for the accumulator ALU skip unit.
// Depends on a clk and an active-low arst_n in the including module.
`ifndef ACCUMULATOR_ALU_SKIP_UNIT_ASSERT_SVH
`define ACCUMULATOR_ALU_SKIP_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define AASU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define AASU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define AASU_ASSERT(lbl, prop, msg)

`define AASU_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

>>> rtl/aasu_pkg.sv
// Shared constants and field codes of the accumulator ALU skip unit.
// No dependencies; imported by the top level.
`default_nettype none

package aasu_pkg;

	localparam int ACC_W  = 16;
	localparam int ADDR_W = 15;
	localparam int NACC   = 4;
	localparam int ASEL_W = 2;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	localparam logic [2:0] FN_COM = 3'd0;
	localparam logic [2:0] FN_NEG = 3'd1;
	localparam logic [2:0] FN_MOV = 3'd2;
	localparam logic [2:0] FN_INC = 3'd3;
	localparam logic [2:0] FN_ADC = 3'd4;
	localparam logic [2:0] FN_SUB = 3'd5;
	localparam logic [2:0] FN_ADD = 3'd6;
	localparam logic [2:0] FN_AND = 3'd7;

	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_ROL  = 2'd1;
	localparam logic [1:0] SH_ROR  = 2'd2;
	localparam logic [1:0] SH_SWAP = 2'd3;

	localparam logic [1:0] CB_KEEP = 2'd0;
	localparam logic [1:0] CB_ZERO = 2'd1;
	localparam logic [1:0] CB_ONE  = 2'd2;
	localparam logic [1:0] CB_COMP = 2'd3;

	localparam logic [2:0] SK_NEVER  = 3'd0;
	localparam logic [2:0] SK_ALWAYS = 3'd1;
	localparam logic [2:0] SK_CZ     = 3'd2;
	localparam logic [2:0] SK_CO     = 3'd3;
	localparam logic [2:0] SK_RZ     = 3'd4;
	localparam logic [2:0] SK_RNZ    = 3'd5;
	localparam logic [2:0] SK_CZ_RZ  = 3'd6;
	localparam logic [2:0] SK_CO_RNZ = 3'd7;

	typedef struct packed {
		logic [ASEL_W-1:0] ssel;
		logic [ASEL_W-1:0] dsel;
		logic [2:0]        func;
		logic [1:0]        shift;
		logic [1:0]        cbase;
		logic              noload;
		logic [2:0]        skip;
	} ins_t;

	function automatic ins_t decode(input logic [ACC_W-1:0] ins);
		ins_t d;
		d.ssel   = ins[14:13];
		d.dsel   = ins[12:11];
		d.func   = ins[10:8];
		d.shift  = ins[7:6];
		d.cbase  = ins[5:4];
		d.noload = ins[3];
		d.skip   = ins[2:0];
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/accumulator_alu_skip_unit.sv
// Accumulator ALU skip unit: executes one ALU instruction per request.
// Depends on aasu_pkg, aasu_ram and accumulator_alu_skip_unit_assert.svh.
//
// Usage:
//   Slave channel s_* carries one instruction request: its word address and
//   the instruction word. Master channel m_* returns one result per request:
//   next address, shifted ALU result, new carry and the load flag.
//   m_tvalid rises once the request has passed the execute stage and been
//   registered in the result register; one request is taken every cycle
//   while the master side keeps up.
//   The accumulators sit in a 4-entry RAM read when a request is accepted;
//   a write made by the instruction leaving the execute stage in that same
//   cycle is forwarded, so dependent instructions run back to back.
//   Reset clears the carry, all accumulator valid bits (an accumulator never
//   written reads as zero) and both stages; no clearing pass is needed.
//   When m_tready is low with a result waiting, the result register holds,
//   the execute stage holds its instruction and the accumulators are not
//   written; s_tready drops once the execute stage is full.
`default_nettype none

`include "accumulator_alu_skip_unit_assert.svh"

module accumulator_alu_skip_unit import aasu_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [14:0] pc_address, [30:15] instruction, [31] zero
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [14:0] next_address, [30:15] alu_result, [31] carry_result,
	// [32] was_loaded, [39:33] zero
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	logic                accept;
	logic                adv;
	logic                out_rdy;
	logic [ADDR_W-1:0]   in_pc;
	ins_t                in_dec;

	logic                s1_vld_q;
	logic [ADDR_W-1:0]   pc_s1;
	logic [ACC_W-1:0]    ins_s1;
	logic                byp_src_s1;
	logic                byp_dst_s1;
	logic [ACC_W-1:0]    byp_data_s1;
	logic                vld_src_s1;
	logic                vld_dst_s1;

	logic [NACC-1:0]     acc_vld_q;
	logic                carry_q;
	logic                out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	ins_t                dec;
	logic [ACC_W-1:0]    rd_src;
	logic [ACC_W-1:0]    rd_dst;
	logic [ACC_W-1:0]    src;
	logic [ACC_W-1:0]    dst;
	logic                base;
	logic [ACC_W:0]      opa;
	logic [ACC_W:0]      fres;
	logic [ACC_W-1:0]    res;
	logic                cout;
	logic                take;
	logic [ADDR_W-1:0]   nxt;
	logic                ram_we;

	assign out_rdy  = !out_vld_q || m_tready;
	assign adv      = s1_vld_q && out_rdy;
	assign s_tready = !s1_vld_q || out_rdy;
	assign accept   = s_tvalid && s_tready;
	assign in_pc    = s_tdata[ADDR_W-1:0];
	assign in_dec   = decode(s_tdata[ADDR_W+ACC_W-1:ADDR_W]);

	assign dec    = decode(ins_s1);
	assign ram_we = adv && !dec.noload;

	aasu_ram #(
		.WIDTH(ACC_W),
		.DEPTH(NACC)
	) u_acc_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (dec.dsel),
		.wdata   (res),
		.re      (accept),
		.raddr_a (in_dec.ssel),
		.raddr_b (in_dec.dsel),
		.rdata_a (rd_src),
		.rdata_b (rd_dst)
	);

	// execute stage request capture, with forwarding of this cycle's writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_tready) begin
			s1_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_s1       <= in_pc;
			ins_s1      <= s_tdata[ADDR_W+ACC_W-1:ADDR_W];
			byp_src_s1  <= ram_we && (dec.dsel == in_dec.ssel);
			byp_dst_s1  <= ram_we && (dec.dsel == in_dec.dsel);
			byp_data_s1 <= res;
			vld_src_s1  <= acc_vld_q[in_dec.ssel];
			vld_dst_s1  <= acc_vld_q[in_dec.dsel];
		end
	end

	always_comb begin
		src = byp_src_s1 ? byp_data_s1 : (vld_src_s1 ? rd_src : '0);
		dst = byp_dst_s1 ? byp_data_s1 : (vld_dst_s1 ? rd_dst : '0);

		case (dec.cbase)
			CB_KEEP: base = carry_q;
			CB_ZERO: base = 1'b0;
			CB_ONE:  base = 1'b1;
			CB_COMP: base = !carry_q;
			default: base = carry_q;
		endcase
		opa = {base, src};

		case (dec.func)
			FN_COM:  fres = {opa[ACC_W], ~src};
			FN_NEG:  fres = {opa[ACC_W], ~src} + {{ACC_W{1'b0}}, 1'b1};
			FN_MOV:  fres = opa;
			FN_INC:  fres = opa + {{ACC_W{1'b0}}, 1'b1};
			FN_ADC:  fres = {opa[ACC_W], ~src} + {1'b0, dst};
			FN_SUB:  fres = {opa[ACC_W], ~src} + {1'b0, dst} + {{ACC_W{1'b0}}, 1'b1};
			FN_ADD:  fres = opa + {1'b0, dst};
			FN_AND:  fres = {opa[ACC_W], src & dst};
			default: fres = opa;
		endcase

		case (dec.shift)
			SH_NONE: begin
				cout = fres[ACC_W];
				res  = fres[ACC_W-1:0];
			end
			SH_ROL: begin
				cout = fres[ACC_W-1];
				res  = {fres[ACC_W-2:0], fres[ACC_W]};
			end
			SH_ROR: begin
				cout = fres[0];
				res  = fres[ACC_W:1];
			end
			SH_SWAP: begin
				cout = fres[ACC_W];
				res  = {fres[7:0], fres[15:8]};
			end
			default: begin
				cout = fres[ACC_W];
				res  = fres[ACC_W-1:0];
			end
		endcase

		case (dec.skip)
			SK_NEVER:  take = 1'b0;
			SK_ALWAYS: take = 1'b1;
			SK_CZ:     take = !cout;
			SK_CO:     take = cout;
			SK_RZ:     take = (res == '0);
			SK_RNZ:    take = (res != '0);
			SK_CZ_RZ:  take = !cout || (res == '0);
			SK_CO_RNZ: take = cout && (res != '0);
			default:   take = 1'b0;
		endcase

		nxt = pc_s1 + {{(ADDR_W-2){1'b0}}, take, !take};
	end

	// writeback of carry and accumulator valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q   <= 1'b0;
			acc_vld_q <= '0;
		end else if (ram_we) begin
			carry_q             <= cout;
			acc_vld_q[dec.dsel] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_rdy) begin
			out_vld_q <= s1_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {7'd0, !dec.noload, cout, res, nxt};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	`AASU_ASSERT_NEXT(a_hold_s1, s1_vld_q && !adv, s1_vld_q, "execute stage dropped a request")
	`AASU_ASSERT(a_we_needs_s1, !s1_vld_q |-> !ram_we, "writeback without an instruction")
	`AASU_ASSERT_NEXT(a_vld_set, ram_we, acc_vld_q[$past(dec.dsel)], "written accumulator not valid")

endmodule

`default_nettype wire

>>> rtl/aasu_ram.sv
// Generic RAM: one write port, two read ports sharing one enable, registered read.
// No dependencies.
`default_nettype none

module aasu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]              rdata_a,
	output logic [WIDTH-1:0]              rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire
